FILE: src/efc_pkg.sv
package efc_pkg;

   // default frame limits
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   // register widths and reset values
   localparam int DIM_W        = 10;
   localparam int LEVEL_W      = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 10;
   localparam logic [DIM_W-1:0]   DEF_IMAGE_DIM  = 10'd512;
   localparam logic [LEVEL_W-1:0] DEF_THRESHOLD  = 8'd150;
   localparam logic [LEVEL_W-1:0] WHITE_LEVEL    = 8'd255;

   // request payload layout
   localparam int REQ_DATA_W = 24;

   // result field widths and payload layout
   localparam int SUM_W      = 26;
   localparam int COUNT_W    = 19;
   localparam int CENT_W     = 9;
   localparam int RSP_DATA_W = 96;
   localparam int SUM_X_LSB  = 0;
   localparam int SUM_Y_LSB  = SUM_X_LSB + SUM_W;
   localparam int COUNT_LSB  = SUM_Y_LSB + SUM_W;
   localparam int CENT_X_LSB = COUNT_LSB + COUNT_W;
   localparam int CENT_Y_LSB = CENT_X_LSB + CENT_W;
   localparam int RSP_USED_W = CENT_Y_LSB + CENT_W;

   // per-pixel class bits
   localparam int CLS_W      = 3;
   localparam int CLS_WHITE  = 0;
   localparam int CLS_DARK   = 1;
   localparam int CLS_ZERO   = 2;

   // per-pixel ray bits from the reverse scan
   localparam int RAY_W      = 2;
   localparam int RAY_DOWN   = 0;
   localparam int RAY_RIGHT  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WIDTH     = 2'd0,
      REG_HEIGHT    = 2'd1,
      REG_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_REV_RD,
      ST_REV_WR,
      ST_FWD_RD,
      ST_FWD_WR,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

FILE: src/enclosed_fill_centroid.sv
// channel  | direction | payload (lowest bit first)
// req      | in        | tdata: red_level, green_level, blue_level
// rsp      | out       | tdata: sum_x, sum_y, pixel_count, centroid_x, centroid_y; tuser: empty
// csr      | in        | csr_wr_en, csr_index, csr_wdata (write only)
//
// a pixel request is taken whenever ready is high; ready is low from the last pixel of a frame
// until the result is in the output register: reverse and forward scans each take a read
// and a write state per pixel, the shared restoring divider runs for x and then y (skipped
// when the count is zero), then the output state loads the result once that register is free.
// reset is synchronous; no clearing pass, every entry read was written in the frame.
// a stalled result holds in the output register while the next frame loads.
module enclosed_fill_centroid
   import efc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // red_level, green_level, blue_level
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // sum_x, sum_y, pixel_count, centroid_x, centroid_y
   output logic                    rsp_tuser,   // empty_region
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW   = $clog2(NPIX);
   localparam int PW   = $clog2(NPIX + 1);
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int XCW  = $clog2(MAX_WIDTH + 1);
   localparam int YCW  = $clog2(MAX_HEIGHT + 1);
   localparam int SXW  = $clog2(MAX_WIDTH * NPIX);
   localparam int SYW  = $clog2(MAX_HEIGHT * NPIX);
   localparam int SW   = (SXW > SYW) ? SXW : SYW;
   localparam int CW   = PW;
   localparam int DCW  = $clog2(SW + 1);
   localparam int PRW  = XCW + YCW;

   // configuration registers
   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [LEVEL_W-1:0] thresh_ff;

   // control and datapath registers
   state_type        state_ff, state_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [XCW-1:0]   w_ff, w_in;
   logic [YCW-1:0]   h_ff, h_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [YW-1:0]    y_ff, y_in;
   logic             run_ff, run_in;
   logic [SW-1:0]    acc_x_ff, acc_x_in;
   logic [SW-1:0]    acc_y_ff, acc_y_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [SW-1:0]    dvd_ff, dvd_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [DCW-1:0]   step_ff, step_in;
   logic             sel_y_ff, sel_y_in;
   logic [CENT_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   // memories and their registered read data
   logic [CLS_W-1:0] cls_mem [NPIX];
   logic [RAY_W-1:0] ray_mem [NPIX];
   logic             col_mem [MAX_WIDTH];
   logic [CLS_W-1:0] cls_rd_ff;
   logic [RAY_W-1:0] ray_rd_ff;
   logic             col_rd_ff;

   // memory write ports
   logic             cls_we, ray_we, col_we;
   logic [AW-1:0]    cls_waddr;
   logic [CLS_W-1:0] cls_wdata;
   logic [RAY_W-1:0] ray_wdata;
   logic             col_wdata;

   // effective frame size and pixel total
   logic [XCW-1:0]   w_eff;
   logic [YCW-1:0]   h_eff;
   logic [PRW-1:0]   total_wide;
   logic [PW-1:0]    total;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = XCW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = XCW'(MAX_WIDTH);
      end else begin
         w_eff = XCW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = YCW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = YCW'(MAX_HEIGHT);
      end else begin
         h_eff = YCW'(height_ff);
      end
   end

   assign total_wide = PRW'(w_eff) * PRW'(h_eff);
   assign total      = PW'(total_wide);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DEF_IMAGE_DIM;
         height_ff <= DEF_IMAGE_DIM;
         thresh_ff <= DEF_THRESHOLD;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_WIDTH:     width_ff  <= DIM_W'(csr_wdata);
            REG_HEIGHT:    height_ff <= DIM_W'(csr_wdata);
            REG_THRESHOLD: thresh_ff <= LEVEL_W'(csr_wdata);
            default:       ;
         endcase
      end
   end

   // pixel classification
   logic [LEVEL_W-1:0] red, green, blue;
   logic [CLS_W-1:0]   load_cls;
   assign red   = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign blue  = req_tdata[23:16];
   always_comb begin
      load_cls            = '0;
      load_cls[CLS_WHITE] = (green == WHITE_LEVEL);
      load_cls[CLS_DARK]  = (red < thresh_ff) || (green < thresh_ff) || (blue < thresh_ff);
      load_cls[CLS_ZERO]  = (green == '0);
   end

   // scan position helpers
   logic x_last, y_last, x_first, y_first;
   assign x_last  = (XCW'(x_ff) == w_ff - XCW'(1));
   assign y_last  = (YCW'(y_ff) == h_ff - YCW'(1));
   assign x_first = (x_ff == '0);
   assign y_first = (y_ff == '0);

   // ray evaluation
   logic             dark_old, row_prev, col_prev, ray_r, ray_d;
   logic             fwd_l, fwd_u, fill, dark_new;
   logic [CLS_W-1:0] fwd_cls;
   logic [PW-1:0]    pos_next;
   logic [CW:0]      trial;
   logic             trial_ge;
   logic [SW-1:0]    quot;

   always_comb begin
      dark_old = cls_rd_ff[CLS_DARK];
      // reverse scan: dark at or right of / below the pixel
      row_prev = x_last ? 1'b0 : run_ff;
      col_prev = y_last ? 1'b0 : col_rd_ff;
      ray_r    = row_prev | dark_old;
      ray_d    = col_prev | dark_old;
      // forward scan: dark at or left of / above, column and row 0 excluded
      fwd_l    = (!x_first & run_ff) | (!x_first & dark_old);
      fwd_u    = (!y_first & col_rd_ff) | (!y_first & dark_old);
      fill     = cls_rd_ff[CLS_WHITE] & ray_rd_ff[RAY_RIGHT] & ray_rd_ff[RAY_DOWN]
                 & fwd_l & fwd_u;
      fwd_cls  = cls_rd_ff;
      if (fill) begin
         fwd_cls            = '0;
         fwd_cls[CLS_ZERO]  = 1'b1;
         fwd_cls[CLS_DARK]  = (thresh_ff != '0);
      end
      dark_new = fwd_cls[CLS_DARK];
      // divider trial subtract
      trial    = {rem_ff, dvd_ff[SW-1]};
      trial_ge = (trial >= {1'b0, count_ff});
      quot     = {dvd_ff[SW-2:0], trial_ge};
      pos_next = pos_ff + PW'(1);
   end

   // sequencer: next state, datapath updates and memory writes
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      addr_in      = addr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      run_in       = run_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      count_in     = count_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      sel_y_in     = sel_y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      cls_we       = 1'b0;
      cls_waddr    = addr_ff;
      cls_wdata    = fwd_cls;
      ray_we       = 1'b0;
      ray_wdata    = {ray_r, ray_d};
      col_we       = 1'b0;
      col_wdata    = ray_d;

      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cls_we    = (32'(pos_ff) < NPIX);
               cls_waddr = AW'(pos_ff);
               cls_wdata = load_cls;
               if (pos_next >= total) begin
                  // frame complete: latch size, start reverse scan
                  pos_in   = '0;
                  w_in     = w_eff;
                  h_in     = h_eff;
                  addr_in  = AW'(total - PW'(1));
                  x_in     = XW'(w_eff - XCW'(1));
                  y_in     = YW'(h_eff - YCW'(1));
                  acc_x_in = '0;
                  acc_y_in = '0;
                  count_in = '0;
                  state_in = ST_REV_RD;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
         ST_REV_RD: begin
            state_in = ST_REV_WR;
         end
         ST_REV_WR: begin
            ray_we = 1'b1;
            col_we = 1'b1;
            run_in = ray_r;
            if (addr_ff == '0) begin
               x_in     = '0;
               y_in     = '0;
               state_in = ST_FWD_RD;
            end else begin
               addr_in  = addr_ff - AW'(1);
               if (x_first) begin
                  x_in = XW'(w_ff - XCW'(1));
                  y_in = y_ff - YW'(1);
               end else begin
                  x_in = x_ff - XW'(1);
               end
               state_in = ST_REV_RD;
            end
         end
         ST_FWD_RD: begin
            state_in = ST_FWD_WR;
         end
         ST_FWD_WR: begin
            cls_we    = fill;
            col_we    = 1'b1;
            col_wdata = (!y_first & col_rd_ff) | (!y_first & dark_new);
            run_in    = (!x_first & run_ff) | (!x_first & dark_new);
            if (fwd_cls[CLS_ZERO]) begin
               acc_x_in = acc_x_ff + SW'(x_ff);
               acc_y_in = acc_y_ff + SW'(y_ff);
               count_in = count_ff + CW'(1);
            end
            if (x_last && y_last) begin
               sel_y_in = 1'b0;
               dvd_in   = acc_x_in;
               rem_in   = '0;
               step_in  = DCW'(SW);
               cx_in    = '0;
               cy_in    = '0;
               state_in = (count_in == '0) ? ST_OUT : ST_DIV;
            end else begin
               addr_in = addr_ff + AW'(1);
               if (x_last) begin
                  x_in = '0;
                  y_in = y_ff + YW'(1);
               end else begin
                  x_in = x_ff + XW'(1);
               end
               state_in = ST_FWD_RD;
            end
         end
         ST_DIV: begin
            // one restoring quotient bit per cycle
            rem_in  = trial_ge ? CW'(trial - {1'b0, count_ff}) : CW'(trial);
            dvd_in  = quot;
            step_in = step_ff - DCW'(1);
            if (step_ff == DCW'(1)) begin
               if (!sel_y_ff) begin
                  cx_in    = CENT_W'(quot);
                  sel_y_in = 1'b1;
                  dvd_in   = acc_y_ff;
                  rem_in   = '0;
                  step_in  = DCW'(SW);
               end else begin
                  cy_in    = CENT_W'(quot);
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[SUM_X_LSB +: SUM_W]    = SUM_W'(acc_x_ff);
               rsp_data_in[SUM_Y_LSB +: SUM_W]    = SUM_W'(acc_y_ff);
               rsp_data_in[COUNT_LSB +: COUNT_W]  = COUNT_W'(count_ff);
               rsp_data_in[CENT_X_LSB +: CENT_W]  = cx_ff;
               rsp_data_in[CENT_Y_LSB +: CENT_W]  = cy_ff;
               rsp_user_in  = (count_ff == '0);
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pos_ff       <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      addr_ff     <= addr_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      run_ff      <= run_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      sel_y_ff    <= sel_y_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // pixel class store
   always_ff @(posedge clock) begin
      if (cls_we) begin
         cls_mem[cls_waddr] <= cls_wdata;
      end
      cls_rd_ff <= cls_mem[addr_ff];
   end

   // right/down ray store
   always_ff @(posedge clock) begin
      if (ray_we) begin
         ray_mem[addr_ff] <= ray_wdata;
      end
      ray_rd_ff <= ray_mem[addr_ff];
   end

   // per-column running flag
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[x_ff] <= col_wdata;
      end
      col_rd_ff <= col_mem[x_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // no pixel taken while a frame is processed
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_tready)
      else $error("request accepted during frame processing");

   // empty flag agrees with count, and an empty result has zero sums and zero centroid_x
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_user_ff == (rsp_data_ff[COUNT_LSB +: COUNT_W] == '0)))
      else $error("empty flag disagrees with pixel count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |->
         (rsp_data_ff[SUM_X_LSB +: SUM_W] == '0) && (rsp_data_ff[SUM_Y_LSB +: SUM_W] == '0)
         && (rsp_data_ff[CENT_X_LSB +: CENT_W] == '0))
      else $error("empty result with nonzero sums");

   // scan coordinates stay inside the latched frame
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FWD_WR || state_ff == ST_REV_WR) |->
         (XCW'(x_ff) < w_ff) && (YCW'(y_ff) < h_ff))
      else $error("scan position outside frame");

endmodule
